>>> hdl/isr_pkg.sv
// shared types, constants and register codes of the idle speed integral regulator
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

  // capture window above target and error clamp, in rpm
  localparam int CAPTURE_WINDOW = 200;
  localparam int ERROR_LIMIT    = 200;

  // queue between classifier and integrator
  localparam int QUEUE_DEPTH   = 2;

  // datapath widths: clamped error, error times gain, quarter of the product, wide sum
  localparam int ERR_W   = 12;
  localparam int GAIN_W  = 8;
  localparam int PROD_W  = ERR_W + GAIN_W + 1;
  localparam int DELTA_W = PROD_W - 2;
  localparam int CORR_W  = 16;
  localparam int SUM_W   = DELTA_W + 1;

  // field widths
  localparam int RPM_W   = 15;
  localparam int TEMP_W  = 16;
  localparam int FLAGS_W = 3;
  localparam int DB_W    = 8;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_FLAGS    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_TARGET   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DEADBAND = 3'd2;
  localparam logic [CIDX_W-1:0] REG_GAIN_POS = 3'd3;
  localparam logic [CIDX_W-1:0] REG_GAIN_NEG = 3'd4;
  localparam logic [CIDX_W-1:0] REG_CORR_MIN = 3'd5;
  localparam logic [CIDX_W-1:0] REG_CORR_MAX = 3'd6;
  localparam logic [CIDX_W-1:0] REG_TURN_ON  = 3'd7;

  // control flag bit positions
  localparam int FLAG_ENABLE = 0;
  localparam int FLAG_GAS_OK = 1;
  localparam int FLAG_SENSOR = 2;

  // register reset values
  localparam logic [RPM_W-1:0]  TARGET_RST   = 15'd900;
  localparam logic [DB_W-1:0]   DEADBAND_RST = 8'd10;
  localparam logic signed [CORR_W-1:0] CORR_MIN_RST = -16'sd480;
  localparam logic signed [CORR_W-1:0] CORR_MAX_RST = 16'sd480;

  // what the integrator does with an item
  typedef enum logic [1:0] {
    KIND_BYPASS = 2'b00,
    KIND_HOLD   = 2'b01,
    KIND_UPDATE = 2'b10
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DELTA_W-1:0] delta;
  } item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]       flags;
    logic [RPM_W-1:0]         target;
    logic [DB_W-1:0]          deadband;
    logic [GAIN_W-1:0]        gain_pos;
    logic [GAIN_W-1:0]        gain_neg;
    logic signed [CORR_W-1:0] corr_min;
    logic signed [CORR_W-1:0] corr_max;
    logic signed [TEMP_W-1:0] turn_on;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/isr_front.sv
// classifier stage: bypass and deadband decisions, error times gain over four
`timescale 1ns / 1ps
`default_nettype none

module isr_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  isr_pkg::cfg_t                    cfg,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [isr_pkg::RPM_W-1:0]        in_engine_rpm,
  input  wire  signed [isr_pkg::TEMP_W-1:0] in_coolant_temp,
  input  wire                              in_on_gas,
  input  wire                              in_period_due,
  output logic                             f_valid,
  output isr_pkg::item_t                   f_item,
  input  wire                              f_take
);
  import isr_pkg::*;

  logic                      f_vld_r, f_vld_nxt;
  item_t                     f_item_r, f_item_nxt;
  logic                      accept;
  logic                      bypass;
  logic [RPM_W+1:0]          rpm_ext, cap_lim;
  logic signed [RPM_W:0]     err_raw;
  logic signed [ERR_W-1:0]   err_c;
  logic [ERR_W-1:0]          mag;
  logic [GAIN_W-1:0]         gain;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_adj;

  // stage is free when empty or when the queue takes its item
  assign in_stall = f_vld_r && !f_take;
  assign accept   = in_valid && !in_stall;

  // bypass conditions
  always_comb begin
    rpm_ext = (RPM_W+2)'(in_engine_rpm);
    cap_lim = (RPM_W+2)'(cfg.target) + (RPM_W+2)'(CAPTURE_WINDOW);
    bypass  = !cfg.flags[FLAG_ENABLE] || (rpm_ext > cap_lim) ||
              (cfg.flags[FLAG_SENSOR] && (in_coolant_temp < cfg.turn_on)) ||
              (in_on_gas && !cfg.flags[FLAG_GAS_OK]);
  end

  // clamped error and its magnitude
  always_comb begin
    err_raw = $signed({1'b0, cfg.target}) - $signed({1'b0, in_engine_rpm});
    if (err_raw > (RPM_W+1)'(ERROR_LIMIT)) begin
      err_c = ERR_W'(ERROR_LIMIT);
    end else if (err_raw < -(RPM_W+1)'(ERROR_LIMIT)) begin
      err_c = -ERR_W'(ERROR_LIMIT);
    end else begin
      err_c = err_raw[ERR_W-1:0];
    end
    mag = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
  end

  // gain by error sign, product divided by four toward zero
  always_comb begin
    gain     = (err_c > 0) ? cfg.gain_pos : cfg.gain_neg;
    prod     = PROD_W'(err_c) * $signed({1'b0, gain});
    prod_adj = prod[PROD_W-1] ? (prod + PROD_W'(3)) : prod;
  end

  // next item
  always_comb begin
    f_item_nxt = f_item_r;
    if (accept) begin
      if (bypass) begin
        f_item_nxt.kind = KIND_BYPASS;
      end else if (mag <= ERR_W'(cfg.deadband)) begin
        f_item_nxt.kind = KIND_HOLD;
      end else begin
        f_item_nxt.kind = KIND_UPDATE;
      end
      f_item_nxt.delta = in_period_due ? prod_adj[PROD_W-1:2] : '0;
    end
    f_vld_nxt = accept ? 1'b1 : (f_vld_r && !f_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
    f_item_r <= f_item_nxt;
  end

  assign f_valid = f_vld_r;
  assign f_item  = f_item_r;

endmodule

`default_nettype wire

>>> hdl/isr_queue.sv
// short fifo of classified items between classifier and integrator
`timescale 1ns / 1ps
`default_nettype none

module isr_queue #(
  parameter int DEPTH = isr_pkg::QUEUE_DEPTH
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  isr_pkg::item_t  push_item,
  output logic            pop_valid,
  input  wire             pop_ready,
  output isr_pkg::item_t  pop_item
);
  import isr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/isr_back.sv
// integrator: stored correction, wide add, limit clamp and output register
`timescale 1ns / 1ps
`default_nettype none

module isr_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  isr_pkg::cfg_t                      cfg,
  input  wire                                q_valid,
  output logic                               q_take,
  input  isr_pkg::item_t                     q_item,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [isr_pkg::CORR_W-1:0]  out_advance_correction
);
  import isr_pkg::*;

  logic signed [CORR_W-1:0] state_r, state_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic signed [CORR_W-1:0] out_r, out_nxt;
  logic signed [SUM_W-1:0]  sum, clamped;

  // take an item when the output register is free or being drained
  assign q_take = q_valid && (!out_vld_r || !out_stall);

  // wide sum, max applied before min
  always_comb begin
    sum     = SUM_W'(state_r) + SUM_W'(q_item.delta);
    clamped = sum;
    if (clamped > SUM_W'(cfg.corr_max)) begin
      clamped = SUM_W'(cfg.corr_max);
    end
    if (clamped < SUM_W'(cfg.corr_min)) begin
      clamped = SUM_W'(cfg.corr_min);
    end
  end

  // result and state update
  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    if (q_take) begin
      case (q_item.kind)
        KIND_BYPASS: out_nxt = '0;
        KIND_HOLD:   out_nxt = state_r;
        KIND_UPDATE: begin
          out_nxt   = clamped[CORR_W-1:0];
          state_nxt = clamped[CORR_W-1:0];
        end
        default:     out_nxt = '0;
      endcase
    end
    out_vld_nxt = q_take ? 1'b1 : (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid              = out_vld_r;
  assign out_advance_correction = out_r;

  // a bypassed item answers zero
  a_bypass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_item.kind == KIND_BYPASS |=> out_vld_r && out_r == '0)
    else $error("bypass item did not answer zero");

  // only an update moves the stored correction
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_take && q_item.kind == KIND_UPDATE) |=> $stable(state_r))
    else $error("stored correction changed without an update");

  // an update leaves the stored correction inside ordered limits
  a_state_limits: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_item.kind == KIND_UPDATE && cfg.corr_min <= cfg.corr_max
    |=> state_r >= cfg.corr_min && state_r <= cfg.corr_max)
    else $error("stored correction outside limits");

  // an update answers the value it stores
  a_update_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_item.kind == KIND_UPDATE |=> out_r == state_r)
    else $error("update answer differs from stored correction");

endmodule

`default_nettype wire

>>> hdl/idle_speed_integral_regulator.sv
// top level: configuration registers, classifier, item queue and integrator
`timescale 1ns / 1ps
`default_nettype none

// Idle speed integral regulator. Takes one sample (engine speed, coolant
// temperature, gas flag, period flag) per clock while in_stall is low and returns
// exactly one advance correction per sample, in order. Throughput is one sample
// per cycle while no stall holds the flow; it is set by the integrator, which
// adds, clamps and stores the correction as it takes each item. Output valid
// rises once the classifier register, item queue and output register are loaded
// in turn after the input transfer. While the output is stalled the input keeps
// flowing for QUEUE_DEPTH + 1 samples: queue entries plus the classifier register.
// Registers are written over the cfg_ port, which is always ready; write them
// only while no sample is in flight. Writes to unknown indexes are dropped.
module idle_speed_integral_regulator #(
  parameter int QUEUE_DEPTH = isr_pkg::QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [isr_pkg::CIDX_W-1:0]         cfg_index,
  input  wire  [isr_pkg::CDAT_W-1:0]         cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [isr_pkg::RPM_W-1:0]          in_engine_rpm,
  input  wire  signed [isr_pkg::TEMP_W-1:0]  in_coolant_temp,
  input  wire                                in_on_gas,
  input  wire                                in_period_due,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [isr_pkg::CORR_W-1:0]  out_advance_correction
);
  import isr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  f_valid, f_take;
  item_t f_item;
  logic  q_valid, q_take;
  item_t q_item;

  assign cfg_ready = 1'b1;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLAGS:    cfg_nxt.flags    = cfg_data[FLAGS_W-1:0];
        REG_TARGET:   cfg_nxt.target   = cfg_data[RPM_W-1:0];
        REG_DEADBAND: cfg_nxt.deadband = cfg_data[DB_W-1:0];
        REG_GAIN_POS: cfg_nxt.gain_pos = cfg_data[GAIN_W-1:0];
        REG_GAIN_NEG: cfg_nxt.gain_neg = cfg_data[GAIN_W-1:0];
        REG_CORR_MIN: cfg_nxt.corr_min = $signed(cfg_data[CORR_W-1:0]);
        REG_CORR_MAX: cfg_nxt.corr_max = $signed(cfg_data[CORR_W-1:0]);
        REG_TURN_ON:  cfg_nxt.turn_on  = $signed(cfg_data[TEMP_W-1:0]);
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flags    <= '0;
      cfg_r.target   <= TARGET_RST;
      cfg_r.deadband <= DEADBAND_RST;
      cfg_r.gain_pos <= '0;
      cfg_r.gain_neg <= '0;
      cfg_r.corr_min <= CORR_MIN_RST;
      cfg_r.corr_max <= CORR_MAX_RST;
      cfg_r.turn_on  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classifier
  isr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_engine_rpm   (in_engine_rpm),
    .in_coolant_temp (in_coolant_temp),
    .in_on_gas       (in_on_gas),
    .in_period_due   (in_period_due),
    .f_valid         (f_valid),
    .f_item          (f_item),
    .f_take          (f_take)
  );

  // item queue
  isr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_take),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_take),
    .pop_item   (q_item)
  );

  // integrator
  isr_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_valid                (q_valid),
    .q_take                 (q_take),
    .q_item                 (q_item),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_advance_correction (out_advance_correction)
  );

endmodule

`default_nettype wire

>>> dv/idle_speed_integral_regulator_tb.sv
// testbench for the idle speed integral regulator: directed and random samples vs a predictor
`timescale 1ns / 1ps

module idle_speed_integral_regulator_tb;
  import isr_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 3;
  localparam int IDLE_PCT      = 11;
  localparam int IDLE_LIMIT    = 1000;
  localparam int HOLD_CYCLES   = 80;
  localparam int HOLD_COUNT    = 2;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 125;
  localparam int CALM_PHASE    = 3;

  typedef struct {
    logic [RPM_W-1:0]         rpm;
    logic signed [TEMP_W-1:0] temp;
    logic                     gas;
    logic                     due;
  } sample_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CIDX_W-1:0]         cfg_index = '0;
  logic [CDAT_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic [RPM_W-1:0]          in_engine_rpm = '0;
  logic signed [TEMP_W-1:0]  in_coolant_temp = '0;
  logic                      in_on_gas = 1'b0;
  logic                      in_period_due = 1'b0;
  logic                      out_stall = 1'b0;
  wire                       cfg_ready;
  wire                       in_stall;
  wire                       out_valid;
  wire signed [CORR_W-1:0]   out_advance_correction;

  // pending samples, expected corrections and bookkeeping
  sample_t                   pending_samples[$];
  logic signed [CORR_W-1:0]  expected_corrections[$];
  int                        queued_total = 0;
  int                        accepted_total = 0;
  int                        results_seen = 0;
  int                        mismatches = 0;
  int                        idle_cycles = 0;
  int                        hold_left = 0;
  int                        holds_done = 0;
  logic                      in_taken = 1'b0;
  logic                      calm = 1'b0;

  // predictor copy of the registers and the integrator
  cfg_t                      model_regs;
  logic signed [CORR_W-1:0]  model_integral;

  idle_speed_integral_regulator dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_engine_rpm          (in_engine_rpm),
    .in_coolant_temp        (in_coolant_temp),
    .in_on_gas              (in_on_gas),
    .in_period_due          (in_period_due),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_advance_correction (out_advance_correction)
  );

  always #HALF_PERIOD clk = ~clk;

  // register write as the block sees it, unused upper bits dropped
  function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    case (idx)
      REG_FLAGS:    model_regs.flags    = data[FLAGS_W-1:0];
      REG_TARGET:   model_regs.target   = data[RPM_W-1:0];
      REG_DEADBAND: model_regs.deadband = data[DB_W-1:0];
      REG_GAIN_POS: model_regs.gain_pos = data[GAIN_W-1:0];
      REG_GAIN_NEG: model_regs.gain_neg = data[GAIN_W-1:0];
      REG_CORR_MIN: model_regs.corr_min = data;
      REG_CORR_MAX: model_regs.corr_max = data;
      REG_TURN_ON:  model_regs.turn_on  = data;
      default: ;
    endcase
  endfunction

  // next advance correction; updates the integrator outside bypass and deadband
  function automatic logic signed [CORR_W-1:0] predict_correction(sample_t s);
    int   target;
    int   rpm;
    int   err;
    int   mag;
    int   gain;
    int   acc;
    logic bypass;
    target = int'(model_regs.target);
    rpm    = int'(s.rpm);
    bypass = !model_regs.flags[FLAG_ENABLE] || rpm > target + CAPTURE_WINDOW ||
             (model_regs.flags[FLAG_SENSOR] &&
              int'($signed(s.temp)) < int'($signed(model_regs.turn_on))) ||
             (s.gas && !model_regs.flags[FLAG_GAS_OK]);
    if (bypass) return '0;
    err = target - rpm;
    if (err > ERROR_LIMIT) err = ERROR_LIMIT;
    if (err < -ERROR_LIMIT) err = -ERROR_LIMIT;
    mag = (err < 0) ? -err : err;
    // deadband holds the stored value as it is
    if (mag <= int'(model_regs.deadband)) return model_integral;
    gain = (err > 0) ? int'(model_regs.gain_pos) : int'(model_regs.gain_neg);
    acc  = int'(model_integral);
    if (s.due) acc += (err * gain) / 4;
    // upper limit first, so inverted limits end at the minimum
    if (acc > int'($signed(model_regs.corr_max))) acc = int'($signed(model_regs.corr_max));
    if (acc < int'($signed(model_regs.corr_min))) acc = int'($signed(model_regs.corr_min));
    model_integral = acc[CORR_W-1:0];
    return model_integral;
  endfunction

  task automatic report_mismatch(string what, logic signed [CORR_W-1:0] want,
                                 logic signed [CORR_W-1:0] got);
    $display("mismatch at %0t ns: %s, expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // one register transfer; valid stays high for a following write
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // all registers, with random junk above the width of each register narrower than the data
  task automatic program_regs(cfg_t c);
    write_reg(REG_FLAGS,    CDAT_W'({$urandom, c.flags}));
    write_reg(REG_TARGET,   CDAT_W'({$urandom, c.target}));
    write_reg(REG_DEADBAND, CDAT_W'({$urandom, c.deadband}));
    write_reg(REG_GAIN_POS, CDAT_W'({$urandom, c.gain_pos}));
    write_reg(REG_GAIN_NEG, CDAT_W'({$urandom, c.gain_neg}));
    write_reg(REG_CORR_MIN, c.corr_min);
    write_reg(REG_CORR_MAX, c.corr_max);
    write_reg(REG_TURN_ON,  c.turn_on);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(int rpm, int temp, bit gas, bit due);
    sample_t s;
    s.rpm  = rpm[RPM_W-1:0];
    s.temp = temp[TEMP_W-1:0];
    s.gas  = gas;
    s.due  = due;
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // mostly speeds near target with a warm engine, the rest over the full field range
  task automatic push_random_sample(cfg_t c);
    int rpm;
    int temp;
    int lo;
    if ($urandom_range(99) < 75) begin
      rpm = int'(c.target) + int'($urandom_range(450)) - 250;
      if (rpm < 0) rpm = 0;
      if (rpm > 32767) rpm = 32767;
    end else begin
      rpm = int'($urandom_range(32767));
    end
    if ($urandom_range(99) < 80) begin
      lo   = int'($signed(c.turn_on));
      temp = lo + int'($urandom_range(32767 - lo));
    end else begin
      temp = int'($signed(TEMP_W'($urandom)));
    end
    push_sample(rpm, temp, 1'($urandom_range(1)), $urandom_range(99) < 70);
  endtask

  // random register setting, inverted limits now and then
  function automatic cfg_t random_setting();
    cfg_t c;
    int   a;
    int   b;
    c.flags    = FLAGS_W'($urandom);
    c.flags[FLAG_ENABLE] = ($urandom_range(99) < 85);
    c.target   = ($urandom_range(9) == 0) ? RPM_W'($urandom) : RPM_W'($urandom_range(3000, 500));
    c.deadband = ($urandom_range(4) == 0) ? DB_W'($urandom) : DB_W'($urandom_range(60));
    c.gain_pos = GAIN_W'($urandom);
    c.gain_neg = GAIN_W'($urandom);
    a = int'($urandom_range(4000)) - 2000;
    b = int'($urandom_range(4000)) - 2000;
    if ((a > b) == ($urandom_range(9) != 0)) begin
      c.corr_min = b[CORR_W-1:0];
      c.corr_max = a[CORR_W-1:0];
    end else begin
      c.corr_min = a[CORR_W-1:0];
      c.corr_max = b[CORR_W-1:0];
    end
    c.turn_on  = CORR_W'(int'($urandom_range(400)) - 200);
    return c;
  endfunction

  // wait until every sample has been answered, then let the pipeline settle
  task automatic wait_idle();
    while (accepted_total != queued_total || expected_corrections.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    sample_t next_sample;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_sample = pending_samples.pop_front();
        in_valid        <= 1'b1;
        in_engine_rpm   <= next_sample.rpm;
        in_coolant_temp <= next_sample.temp;
        in_on_gas       <= next_sample.gas;
        in_period_due   <= next_sample.due;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-offs while samples keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < HOLD_COUNT && results_seen > 50 && pending_samples.size() > 20) begin
      hold_left = HOLD_CYCLES - 1;
      holds_done++;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: predict on input transfer, check on output transfer, watchdog
  always @(posedge clk) begin
    sample_t                  taken;
    logic                     out_taken;
    logic signed [CORR_W-1:0] want;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (in_taken) begin
      taken.rpm  = in_engine_rpm;
      taken.temp = in_coolant_temp;
      taken.gas  = in_on_gas;
      taken.due  = in_period_due;
      expected_corrections.push_back(predict_correction(taken));
      accepted_total++;
    end
    if (out_taken) begin
      results_seen++;
      if (expected_corrections.size() == 0) begin
        report_mismatch("result with no sample waiting", '0, out_advance_correction);
      end else begin
        want = expected_corrections.pop_front();
        if (out_advance_correction !== want)
          report_mismatch("advance_correction", want, out_advance_correction);
      end
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    cfg_t c;
    model_regs = '{flags: '0, target: TARGET_RST, deadband: DEADBAND_RST, gain_pos: '0,
                   gain_neg: '0, corr_min: CORR_MIN_RST, corr_max: CORR_MAX_RST, turn_on: '0};
    model_integral = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: regulator disabled, always zero
    push_sample(900, 100, 0, 1);
    push_sample(0, -5, 1, 1);
    wait_idle();

    // enabled with all conditions, full gains
    c = '{flags: 3'b111, target: 15'd1000, deadband: 8'd10, gain_pos: 8'd255, gain_neg: 8'd255,
          corr_min: -16'sd480, corr_max: 16'sd480, turn_on: '0};
    program_regs(c);
    push_sample(0, 100, 0, 1);          // error clamped high, hits upper limit
    push_sample(1200, 100, 0, 1);       // top of capture window, error clamped low
    push_sample(1201, 100, 0, 1);       // just above capture window
    push_sample(32767, -1, 1, 0);       // top speed
    push_sample(1010, 0, 0, 1);         // deadband edge from above, temp at turn-on
    push_sample(990, 32767, 0, 1);      // deadband edge from below, hottest
    push_sample(1011, 50, 0, 0);        // period not due, clamp only
    push_sample(989, 50, 1, 1);         // gas allowed, small positive step
    push_sample(1011, 50, 0, 1);        // small negative step
    push_sample(900, -32768, 0, 1);     // cold with sensor fitted
    push_sample(900, 0, 1, 1);
    wait_idle();

    // gas not allowed
    c.flags = 3'b101;
    program_regs(c);
    push_sample(900, 0, 1, 1);
    push_sample(900, 0, 0, 0);
    wait_idle();

    // no sensor, small gains for truncation toward zero
    c.flags    = 3'b001;
    c.gain_pos = 8'd1;
    c.gain_neg = 8'd3;
    program_regs(c);
    push_sample(1050, -32768, 0, 1);
    push_sample(1011, -32768, 0, 1);
    push_sample(987, 5, 0, 1);
    push_sample(1100, 5, 0, 1);
    wait_idle();

    // inverted limits
    c.corr_min = 16'sd100;
    c.corr_max = -16'sd100;
    program_regs(c);
    push_sample(1100, 5, 0, 1);
    push_sample(900, 5, 0, 0);
    push_sample(1005, 5, 0, 1);
    wait_idle();

    // random phases, the first two at the register extremes
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: c = '{flags: 3'b111, target: 15'h7fff, deadband: 8'hff, gain_pos: 8'hff,
                 gain_neg: 8'hff, corr_min: 16'sh8000, corr_max: 16'sh7fff,
                 turn_on: 16'sh7fff};
        1: c = '{flags: 3'b111, target: '0, deadband: '0, gain_pos: 8'hff, gain_neg: 8'hff,
                 corr_min: 16'sh8000, corr_max: 16'sh7fff, turn_on: 16'sh8000};
        default: c = random_setting();
      endcase
      calm = (phase == CALM_PHASE);
      program_regs(c);
      repeat (PHASE_SAMPLES) push_random_sample(c);
      wait_idle();
    end

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
